@@ rtl/ppe_pkg.sv @@
// Shared constants, codes and helper functions of the piecewise polynomial evaluator.
package ppe_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_DIMS     = 4;
    localparam int MAX_DEGREE   = 3;
    localparam int ROW_WORDS    = MAX_DIMS * (MAX_DEGREE + 1);
    localparam int COEF_DEPTH   = MAX_SEGMENTS * ROW_WORDS;
    localparam int BRK_DEPTH    = MAX_SEGMENTS + 1;
    localparam int DATA_W       = 32;
    localparam int SEG_W        = 7;
    localparam int SLOT_W       = 4;
    localparam int CFG_W        = 7;

    typedef enum logic [1:0] {
        MODE_COEF = 2'd0,
        MODE_BRK  = 2'd1,
        MODE_EVAL = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_CLOSED = 2'd0,
        CFG_DEGREE = 2'd1,
        CFG_DIMS   = 2'd2,
        CFG_SEGS   = 2'd3
    } cfg_idx_t;

    // falling factorial n (n-1) ... (n-k+1), n and k up to 3
    function automatic logic [2:0] ffact(input logic [1:0] n, input logic [1:0] k);
        logic [2:0] w;
        w = 3'd1;
        if (k >= 2'd1) w = 3'(n);
        if (k >= 2'd2) w = (n == 2'd3) ? 3'd6 : ((n == 2'd2) ? 3'd2 : 3'd0);
        if (k == 2'd3) w = (n == 2'd3) ? 3'd6 : 3'd0;
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh7FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -50'sh80000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/ppe_if.sv @@
// Valid/ready word channels for input items and results.
interface ppe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic signed [31:0] param_t;
    logic [1:0]  deriv_order;
    logic [6:0]  seg_index;
    logic [3:0]  coef_slot;
    logic signed [31:0] load_value;
    modport source (output valid, mode, param_t, deriv_order, seg_index, coef_slot,
                    load_value, input ready);
    modport sink   (input valid, mode, param_t, deriv_order, seg_index, coef_slot,
                    load_value, output ready);
endinterface

interface ppe_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] component_value;
    logic [1:0]  component_index;
    logic        last_component;
    modport source (output valid, component_value, component_index, last_component,
                    input ready);
    modport sink   (input valid, component_value, component_index, last_component,
                    output ready);
endinterface

@@ rtl/piecewise_poly_evaluator_unit.sv @@
// Piecewise polynomial evaluator top level: tables, sequencer and Horner datapath.
// Usage:
//   item   : input words. mode selects coefficient write, breakpoint write or evaluate.
//            Load words are written when accepted and give no result.
//   result : one word per component of an evaluation, last_component on the final one.
//   cfg_*  : register writes (closed_curve, poly_degree, dims_in_use, segments_in_use),
//            to be issued by the user only while idle; the block does not enforce it.
// An evaluate word reads the end breakpoint and decides wrap or clamp, using the serial
// remainder unit when a closed curve needs it. It then scans breakpoints (up to
// segments_in_use), reads the segment base and, for each component, runs the Horner
// steps, one coefficient read and one shared multiply per step (none when
// deriv_order > poly_degree), before it presents the result.
// One word is worked at a time; item.ready is high only while idle. Breakpoint and
// coefficient tables are single-port RAMs, so each scan and Horner step waits for
// its registered read data. A result is held until taken; a stalled receiver
// stalls the block. Reset clears the sequencer and restores register defaults;
// table contents are undefined until written.
module piecewise_poly_evaluator_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    ppe_in_if.sink           item,
    ppe_out_if.source        result
);
    typedef enum logic [3:0] {
        S_IDLE, S_END_RD, S_WRAP, S_REM, S_SCAN_RD, S_SCAN_CK, S_BASE_RD, S_BASE_CK,
        S_HSTART, S_H_RD, S_H_ACC, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic       closed_reg;
    logic [1:0] degree_reg;
    logic [2:0] dims_cfg_reg;
    logic [6:0] segs_cfg_reg;

    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] end_reg, end_next;
    logic signed [31:0] local_reg, local_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [6:0] c_reg, c_next;
    logic [5:0] j_reg, j_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] order_reg, order_next;
    logic       neg_reg, neg_next;

    logic [1:0] deg;
    logic [2:0] dims;
    logic [6:0] segs;

    logic        brk_we, coef_we;
    logic [6:0]  brk_addr;
    logic [9:0]  coef_addr;
    logic [31:0] brk_rdata, coef_rdata;
    logic signed [31:0] brk_rd, coef_rd;

    logic        rem_start, rem_done;
    logic [31:0] rem_dvd, rem_val;

    logic        accept;
    logic [3:0]  slot_sel;
    logic signed [32:0] diff;
    logic signed [63:0] rnd;
    logic signed [35:0] wc;
    logic signed [49:0] sum;
    logic [2:0]  w;

    assign deg  = degree_reg;
    assign dims = (dims_cfg_reg == 3'd0) ? 3'd1 :
                  ((dims_cfg_reg > 3'(ppe_pkg::MAX_DIMS)) ? 3'(ppe_pkg::MAX_DIMS) : dims_cfg_reg);
    assign segs = (segs_cfg_reg == 7'd0) ? 7'd1 :
                  ((segs_cfg_reg > 7'(ppe_pkg::MAX_SEGMENTS)) ? 7'(ppe_pkg::MAX_SEGMENTS)
                                                               : segs_cfg_reg);

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    assign brk_rd  = brk_rdata;
    assign coef_rd = coef_rdata;

    always_comb
    begin
        brk_we  = accept && (item.mode == ppe_pkg::MODE_BRK) &&
                  (item.seg_index <= 7'(ppe_pkg::MAX_SEGMENTS));
        coef_we = accept && (item.mode == ppe_pkg::MODE_COEF) &&
                  (item.seg_index < 7'(ppe_pkg::MAX_SEGMENTS));
        slot_sel = 4'(i_reg) * 4'(dims) + 4'(comp_reg);
        case (state_reg)
            S_END_RD:  brk_addr = segs;
            S_SCAN_RD: brk_addr = c_reg + 7'd1;
            S_BASE_RD: brk_addr = {1'b0, j_reg};
            default:   brk_addr = item.seg_index;
        endcase
        if (state_reg == S_H_RD)
            coef_addr = {j_reg, slot_sel};
        else
            coef_addr = {item.seg_index[5:0], item.coef_slot};
    end

    ppe_ram #(.WIDTH(ppe_pkg::DATA_W), .DEPTH(ppe_pkg::BRK_DEPTH)) u_brk_ram (
        .clk   (clk),
        .we    (brk_we),
        .addr  (brk_addr),
        .wdata (item.load_value),
        .rdata (brk_rdata)
    );

    ppe_ram #(.WIDTH(ppe_pkg::DATA_W), .DEPTH(ppe_pkg::COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .addr  (coef_addr),
        .wdata (item.load_value),
        .rdata (coef_rdata)
    );

    // divisor is sampled on start, while the end breakpoint is on the read port
    ppe_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dvd),
        .divisor  (brk_rdata),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_comb
    begin
        w    = ppe_pkg::ffact(deg - i_reg, order_reg);
        rnd  = (prod_reg + 64'sd32768) >>> 16;
        wc   = $signed({1'b0, w}) * coef_rd;
        sum  = $signed(rnd[47:0]) + $signed(wc);
        diff = 33'(t_reg) - 33'(brk_rd);
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        end_next   = end_reg;
        local_next = local_reg;
        v_next     = v_reg;
        prod_next  = prod_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        comp_next  = comp_reg;
        order_next = order_reg;
        neg_next   = neg_reg;
        rem_start  = 1'b0;
        rem_dvd    = 32'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.mode == ppe_pkg::MODE_EVAL)
                begin
                    t_next     = item.param_t;
                    order_next = item.deriv_order;
                    state_next = S_END_RD;
                end
            end
            S_END_RD:
            begin
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                end_next   = brk_rd;
                c_next     = 7'd0;
                state_next = S_SCAN_RD;
                if (closed_reg)
                begin
                    if (brk_rd <= 32'sd0)
                        t_next = 32'sd0;
                    else if (t_reg < 32'sd0)
                    begin
                        rem_start  = 1'b1;
                        rem_dvd    = 32'd0 - t_reg;
                        neg_next   = 1'b1;
                        state_next = S_REM;
                    end
                    else if (t_reg > brk_rd)
                    begin
                        rem_start  = 1'b1;
                        rem_dvd    = t_reg - 32'sd1;
                        neg_next   = 1'b0;
                        state_next = S_REM;
                    end
                end
                else if (t_reg < 32'sd0)
                    t_next = 32'sd0;
                else if (t_reg > brk_rd)
                    t_next = brk_rd;
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    if (neg_reg)
                        t_next = (rem_val == 32'd0) ? 32'sd0 : end_reg - $signed(rem_val);
                    else
                        t_next = $signed(rem_val) + 32'sd1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (brk_rd >= t_reg || c_reg == segs - 7'd1)
                begin
                    j_next     = c_reg[5:0];
                    state_next = S_BASE_RD;
                end
                else
                begin
                    c_next     = c_reg + 7'd1;
                    state_next = S_SCAN_RD;
                end
            end
            S_BASE_RD:
            begin
                state_next = S_BASE_CK;
            end
            S_BASE_CK:
            begin
                local_next = ppe_pkg::sat32(50'(diff));
                comp_next  = 2'd0;
                state_next = S_HSTART;
            end
            S_HSTART:
            begin
                v_next     = 32'sd0;
                i_next     = 2'd0;
                state_next = (order_reg > deg) ? S_OUT : S_H_RD;
            end
            S_H_RD:
            begin
                prod_next  = v_reg * local_reg;
                state_next = S_H_ACC;
            end
            S_H_ACC:
            begin
                v_next = ppe_pkg::sat32(sum);
                if (i_reg + order_reg == deg)
                    state_next = S_OUT;
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_H_RD;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    if (3'(comp_reg) + 3'd1 == dims)
                        state_next = S_IDLE;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_HSTART;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            closed_reg   <= 1'b0;
            degree_reg   <= 2'd3;
            dims_cfg_reg <= 3'd2;
            segs_cfg_reg <= 7'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ppe_pkg::CFG_CLOSED: closed_reg   <= cfg_data[0];
                    ppe_pkg::CFG_DEGREE: degree_reg   <= cfg_data[1:0];
                    ppe_pkg::CFG_DIMS:   dims_cfg_reg <= cfg_data[2:0];
                    ppe_pkg::CFG_SEGS:   segs_cfg_reg <= cfg_data;
                    default:             closed_reg   <= closed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        end_reg   <= end_next;
        local_reg <= local_next;
        v_reg     <= v_next;
        prod_reg  <= prod_next;
        c_reg     <= c_next;
        j_reg     <= j_next;
        i_reg     <= i_next;
        comp_reg  <= comp_next;
        order_reg <= order_next;
        neg_reg   <= neg_next;
    end

    assign result.valid           = (state_reg == S_OUT);
    assign result.component_value = v_reg;
    assign result.component_index = comp_reg;
    assign result.last_component  = (3'(comp_reg) + 3'd1 == dims);
endmodule

@@ rtl/ppe_ram.sv @@
// Generic single-port RAM with registered read.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/ppe_rem.sv @@
// Bit-serial unsigned remainder unit, one quotient bit per cycle.
module ppe_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    always_comb
    begin
        trial     = {r_reg[31:0], q_reg[31]};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            r_next    = 33'd0;
            q_next    = dividend;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next   = (trial >= {1'b0, d_reg}) ? trial - {1'b0, d_reg} : trial;
            q_next   = {q_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg[31:0];
endmodule

@@ rtl/ppe_chk.sv @@
// Port-level checker for the evaluator, bound to the top level.
module ppe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result word dropped or changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && in_ready)
        else $error("evaluation did not end after last component");
endmodule

bind piecewise_poly_evaluator_unit ppe_chk u_ppe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.component_value),
    .out_last  (result.last_component)
);
